// File: src/crct_pkg.sv
// Shared types and constants for the Catmull-Rom curve tessellator.
// Holds the controller state encoding, the datapath command and status
// structs and the fixed widths of the weight arithmetic. No dependencies.
`timescale 1ns / 1ps

package crct_pkg;

  localparam int SEG_W = 5;
  localparam logic [SEG_W-1:0] SEG_RESET = 5'd20;

  localparam int SQ_W = 2 * SEG_W;
  localparam int CU_W = 3 * SEG_W;
  localparam int RAW_W = CU_W + 5;
  localparam int ROFF_W = CU_W + 2;
  localparam int DEN_W = CU_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_ONE = 65536;
  localparam int FRAC_HALF = 32768;
  localparam int NUM_W = ROFF_W + FRAC_BITS + 1;
  localparam int Q_W = NUM_W - DEN_W;
  localparam int W_W = FRAC_BITS + 2;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam int NUM_COORDS = 3;
  localparam int NUM_TAPS = 4;

  localparam logic [1:0] HIST_AGE0 = 2'd0;
  localparam logic [1:0] HIST_AGE1 = 2'd1;
  localparam logic [1:0] HIST_AGE2 = 2'd2;
  localparam logic [1:0] COORD_LAST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL_A,
    ST_SEL_B,
    ST_RAW1,
    ST_RAW2,
    ST_RAW3,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_LOAD,
    ST_PASS,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SEL_A,
    OP_SEL_B,
    OP_RAW1,
    OP_RAW2,
    OP_RAW3,
    OP_DIV,
    OP_MUL,
    OP_ACC,
    OP_LOAD_CURVE,
    OP_LOAD_POINT,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [1:0]       hist_o;
    logic [SEG_W-1:0] seg_s;
    logic [SEG_W-1:0] seg_n;
    logic [1:0]       coord;
    logic             run_last;
    logic             curve_end;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// File: src/crct_datapath.sv
// Datapath of the tessellator: point history, tap registers, weight
// generation with four restoring dividers, weighting multipliers and the
// output register. Depends on crct_pkg and is driven by crct_ctrl.
`timescale 1ns / 1ps

module crct_datapath #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crct_pkg::dp_cmd_t             cmd,
  output crct_pkg::dp_stat_t            stat,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          out_valid,
  output logic                          out_last,
  output logic                          out_end,
  input  logic                          out_ready
);

  localparam int W = COORD_WIDTH;
  localparam int PW = W + crct_pkg::W_W;
  localparam int SUM_W = PW + 2;
  localparam int TOP_W = SUM_W - W + 1;

  logic signed [W-1:0] in_r   [crct_pkg::NUM_COORDS];
  logic signed [W-1:0] hist_r [crct_pkg::NUM_COORDS][3];
  logic signed [W-1:0] p_r    [crct_pkg::NUM_COORDS][crct_pkg::NUM_TAPS];
  logic signed [W-1:0] res_r  [crct_pkg::NUM_COORDS];

  logic [crct_pkg::SQ_W-1:0]  s2_r, n2_r;
  logic [crct_pkg::CU_W-1:0]  sn2_r, s2n_r, s3_r, n3_r;
  logic [crct_pkg::DEN_W-1:0] den_r;
  logic [crct_pkg::DEN_W-1:0] rem_r [crct_pkg::NUM_TAPS];
  logic [crct_pkg::Q_W-1:0]   dvd_r [crct_pkg::NUM_TAPS];
  logic signed [PW-1:0]       prod_r [crct_pkg::NUM_TAPS];

  logic signed [W-1:0] out_x_r, out_y_r, out_z_r;
  logic                out_valid_r, out_last_r, out_end_r;

  logic signed [crct_pkg::RAW_W-1:0] t_n3, t_sn2, t_s2n, t_s3;
  logic signed [crct_pkg::RAW_W-1:0] raw_w [crct_pkg::NUM_TAPS];
  logic [crct_pkg::NUM_W-1:0]        num_w [crct_pkg::NUM_TAPS];
  logic [crct_pkg::DEN_W:0]          rs_w  [crct_pkg::NUM_TAPS];
  logic [crct_pkg::DEN_W:0]          df_w  [crct_pkg::NUM_TAPS];
  logic                              ge_w  [crct_pkg::NUM_TAPS];
  logic signed [crct_pkg::Q_W:0]     wx_w  [crct_pkg::NUM_TAPS];
  logic signed [crct_pkg::W_W-1:0]   wt_w  [crct_pkg::NUM_TAPS];
  logic signed [PW-1:0]              mul_w [crct_pkg::NUM_TAPS];
  logic signed [W-1:0]               hsel_w [crct_pkg::NUM_COORDS];

  logic signed [SUM_W-1:0] sum_w, rnd_w, sh_w;
  logic [TOP_W-1:0]        top_w;
  logic                    fits_w;
  logic signed [W-1:0]     sat_w;

  always_comb begin
    t_n3  = $signed({{(crct_pkg::RAW_W - crct_pkg::CU_W){1'b0}}, n3_r});
    t_sn2 = $signed({{(crct_pkg::RAW_W - crct_pkg::CU_W){1'b0}}, sn2_r});
    t_s2n = $signed({{(crct_pkg::RAW_W - crct_pkg::CU_W){1'b0}}, s2n_r});
    t_s3  = $signed({{(crct_pkg::RAW_W - crct_pkg::CU_W){1'b0}}, s3_r});
    // Each weight numerator is offset by one full denominator so it stays positive.
    raw_w[0] = (t_n3 <<< 1) - t_sn2 + (t_s2n <<< 1) - t_s3;
    raw_w[1] = (t_n3 <<< 2) - ((t_s2n <<< 2) + t_s2n) + ((t_s3 <<< 1) + t_s3);
    raw_w[2] = (t_n3 <<< 1) + t_sn2 + (t_s2n <<< 2) - ((t_s3 <<< 1) + t_s3);
    raw_w[3] = (t_n3 <<< 1) - t_s2n + t_s3;
    for (int i = 0; i < crct_pkg::NUM_TAPS; i++) begin
      num_w[i] = crct_pkg::NUM_W'({raw_w[i][crct_pkg::ROFF_W-1:0],
                                   {crct_pkg::FRAC_BITS{1'b0}}})
               + crct_pkg::NUM_W'(n3_r);
      rs_w[i] = {rem_r[i], dvd_r[i][crct_pkg::Q_W-1]};
      df_w[i] = rs_w[i] - {1'b0, den_r};
      ge_w[i] = (rs_w[i] >= {1'b0, den_r});
      wx_w[i] = $signed({1'b0, dvd_r[i]}) - $signed((crct_pkg::Q_W + 1)'(crct_pkg::FRAC_ONE));
      wt_w[i] = wx_w[i][crct_pkg::W_W-1:0];
      mul_w[i] = p_r[cmd.coord][i] * wt_w[i];
    end
  end

  always_comb begin
    for (int c = 0; c < crct_pkg::NUM_COORDS; c++) begin
      unique case (cmd.hist_o)
        crct_pkg::HIST_AGE0: hsel_w[c] = hist_r[c][0];
        crct_pkg::HIST_AGE1: hsel_w[c] = hist_r[c][1];
        default:             hsel_w[c] = hist_r[c][2];
      endcase
    end
  end

  always_comb begin
    sum_w = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);
    rnd_w = sum_w + SUM_W'(crct_pkg::FRAC_HALF);
    sh_w = rnd_w >>> crct_pkg::FRAC_BITS;
    top_w = sh_w[SUM_W-1:W-1];
    fits_w = (&top_w) | ~(|top_w);
    if (fits_w) begin
      sat_w = sh_w[W-1:0];
    end else if (sh_w[SUM_W-1]) begin
      sat_w = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int c = 0; c < crct_pkg::NUM_COORDS; c++) begin
        for (int a = 0; a < 3; a++) begin
          hist_r[c][a] <= '0;
        end
      end
    end else begin
      if (cmd.op == crct_pkg::OP_LOAD_CURVE || cmd.op == crct_pkg::OP_LOAD_POINT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.op == crct_pkg::OP_PUSH) begin
        for (int c = 0; c < crct_pkg::NUM_COORDS; c++) begin
          hist_r[c][2] <= hist_r[c][1];
          hist_r[c][1] <= hist_r[c][0];
          hist_r[c][0] <= in_r[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      crct_pkg::OP_CAPTURE: begin
        in_r[0] <= in_x;
        in_r[1] <= in_y;
        in_r[2] <= in_z;
      end
      crct_pkg::OP_SEL_A: begin
        for (int c = 0; c < crct_pkg::NUM_COORDS; c++) begin
          p_r[c][0] <= hsel_w[c];
          p_r[c][1] <= hist_r[c][1];
          p_r[c][2] <= hist_r[c][0];
          p_r[c][3] <= in_r[c];
        end
      end
      crct_pkg::OP_SEL_B: begin
        for (int c = 0; c < crct_pkg::NUM_COORDS; c++) begin
          p_r[c][0] <= hsel_w[c];
          p_r[c][1] <= hist_r[c][0];
          p_r[c][2] <= in_r[c];
          p_r[c][3] <= in_r[c];
        end
      end
      crct_pkg::OP_RAW1: begin
        s2_r <= {{crct_pkg::SEG_W{1'b0}}, cmd.seg_s} * {{crct_pkg::SEG_W{1'b0}}, cmd.seg_s};
        n2_r <= {{crct_pkg::SEG_W{1'b0}}, cmd.seg_n} * {{crct_pkg::SEG_W{1'b0}}, cmd.seg_n};
      end
      crct_pkg::OP_RAW2: begin
        sn2_r <= {{crct_pkg::SEG_W{1'b0}}, n2_r} * {{crct_pkg::SQ_W{1'b0}}, cmd.seg_s};
        s2n_r <= {{crct_pkg::SEG_W{1'b0}}, s2_r} * {{crct_pkg::SQ_W{1'b0}}, cmd.seg_n};
        s3_r  <= {{crct_pkg::SEG_W{1'b0}}, s2_r} * {{crct_pkg::SQ_W{1'b0}}, cmd.seg_s};
        n3_r  <= {{crct_pkg::SEG_W{1'b0}}, n2_r} * {{crct_pkg::SQ_W{1'b0}}, cmd.seg_n};
      end
      crct_pkg::OP_RAW3: begin
        den_r <= {n3_r, 1'b0};
        for (int i = 0; i < crct_pkg::NUM_TAPS; i++) begin
          rem_r[i] <= num_w[i][crct_pkg::NUM_W-1 -: crct_pkg::DEN_W];
          dvd_r[i] <= num_w[i][crct_pkg::Q_W-1:0];
        end
      end
      crct_pkg::OP_DIV: begin
        for (int i = 0; i < crct_pkg::NUM_TAPS; i++) begin
          rem_r[i] <= ge_w[i] ? df_w[i][crct_pkg::DEN_W-1:0] : rs_w[i][crct_pkg::DEN_W-1:0];
          dvd_r[i] <= {dvd_r[i][crct_pkg::Q_W-2:0], ge_w[i]};
        end
      end
      crct_pkg::OP_MUL: begin
        for (int i = 0; i < crct_pkg::NUM_TAPS; i++) begin
          prod_r[i] <= mul_w[i];
        end
      end
      crct_pkg::OP_ACC: begin
        res_r[cmd.coord] <= sat_w;
      end
      crct_pkg::OP_LOAD_CURVE: begin
        out_x_r    <= res_r[0];
        out_y_r    <= res_r[1];
        out_z_r    <= res_r[2];
        out_last_r <= cmd.run_last;
        out_end_r  <= cmd.curve_end;
      end
      crct_pkg::OP_LOAD_POINT: begin
        out_x_r    <= in_r[0];
        out_y_r    <= in_r[1];
        out_z_r    <= in_r[2];
        out_last_r <= cmd.run_last;
        out_end_r  <= cmd.curve_end;
      end
      default: begin
      end
    endcase
  end

  assign stat.out_free = ~out_valid_r | out_ready;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_end   = out_end_r;

endmodule

// File: src/crct_ctrl.sv
// Controller of the tessellator: segment register, points-seen count and
// the state machine that sequences intervals and curve points.
// Depends on crct_pkg; drives crct_datapath through a command struct.
`timescale 1ns / 1ps

module crct_ctrl #(
  parameter int MAX_SEGMENTS = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [crct_pkg::SEG_W-1:0]   cfg_data,
  output crct_pkg::dp_cmd_t            cmd,
  input  crct_pkg::dp_stat_t           stat
);

  localparam logic [crct_pkg::SEG_W-1:0] NMAX = crct_pkg::SEG_W'(MAX_SEGMENTS);
  localparam logic [crct_pkg::CNT_W-1:0] CNT_LAST = crct_pkg::CNT_W'(crct_pkg::DIV_STEPS - 1);

  crct_pkg::state_t state_r, state_nxt;
  logic [crct_pkg::SEG_W-1:0] seg_r;
  logic [1:0]                 seen_r, seen_nxt;
  logic [crct_pkg::SEG_W-1:0] n_r, n_nxt;
  logic [crct_pkg::SEG_W-1:0] s_r, s_nxt;
  logic [crct_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                 k_r, k_nxt;
  logic                       fin_r, fin_nxt;
  logic                       do_b_r, do_b_nxt;
  logic                       phase_b_r, phase_b_nxt;

  logic [crct_pkg::SEG_W-1:0] n_clamp;
  logic                       pass_w, do_a_w, do_b_w, last_s_w;

  assign n_clamp  = (seg_r > NMAX) ? NMAX : seg_r;
  assign pass_w   = (n_clamp == '0) || (seen_r == 2'd0 && in_tlast);
  assign do_a_w   = !pass_w && (seen_r >= 2'd2);
  assign do_b_w   = !pass_w && in_tlast && (seen_r != 2'd0);
  assign last_s_w = (s_r == n_r - crct_pkg::SEG_W'(1));

  always_comb begin
    state_nxt   = state_r;
    seen_nxt    = seen_r;
    n_nxt       = n_r;
    s_nxt       = s_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    fin_nxt     = fin_r;
    do_b_nxt    = do_b_r;
    phase_b_nxt = phase_b_r;
    unique case (state_r)
      crct_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt    = n_clamp;
          fin_nxt  = in_tlast;
          do_b_nxt = do_b_w;
          priority if (pass_w) begin
            state_nxt = crct_pkg::ST_PASS;
          end else if (do_a_w) begin
            state_nxt = crct_pkg::ST_SEL_A;
          end else if (do_b_w) begin
            state_nxt = crct_pkg::ST_SEL_B;
          end else begin
            state_nxt = crct_pkg::ST_DONE;
          end
        end
      end
      crct_pkg::ST_SEL_A: begin
        phase_b_nxt = 1'b0;
        s_nxt       = '0;
        state_nxt   = crct_pkg::ST_RAW1;
      end
      crct_pkg::ST_SEL_B: begin
        phase_b_nxt = 1'b1;
        s_nxt       = '0;
        state_nxt   = crct_pkg::ST_RAW1;
      end
      crct_pkg::ST_RAW1: state_nxt = crct_pkg::ST_RAW2;
      crct_pkg::ST_RAW2: state_nxt = crct_pkg::ST_RAW3;
      crct_pkg::ST_RAW3: begin
        cnt_nxt   = '0;
        state_nxt = crct_pkg::ST_DIV;
      end
      crct_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + crct_pkg::CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          k_nxt     = '0;
          state_nxt = crct_pkg::ST_MUL;
        end
      end
      crct_pkg::ST_MUL: state_nxt = crct_pkg::ST_ACC;
      crct_pkg::ST_ACC: begin
        if (k_r == crct_pkg::COORD_LAST) begin
          state_nxt = crct_pkg::ST_LOAD;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = crct_pkg::ST_MUL;
        end
      end
      crct_pkg::ST_LOAD: begin
        if (stat.out_free) begin
          priority if (!last_s_w) begin
            s_nxt     = s_r + crct_pkg::SEG_W'(1);
            state_nxt = crct_pkg::ST_RAW1;
          end else if (!phase_b_r && do_b_r) begin
            state_nxt = crct_pkg::ST_SEL_B;
          end else if (phase_b_r) begin
            state_nxt = crct_pkg::ST_FINAL;
          end else begin
            state_nxt = crct_pkg::ST_DONE;
          end
        end
      end
      crct_pkg::ST_PASS, crct_pkg::ST_FINAL: begin
        if (stat.out_free) begin
          state_nxt = crct_pkg::ST_DONE;
        end
      end
      crct_pkg::ST_DONE: begin
        if (fin_r) begin
          seen_nxt = 2'd0;
        end else if (seen_r != 2'd3) begin
          seen_nxt = seen_r + 2'd1;
        end
        state_nxt = crct_pkg::ST_IDLE;
      end
      default: state_nxt = crct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = crct_pkg::OP_NONE;
    cmd.hist_o    = crct_pkg::HIST_AGE0;
    cmd.seg_s     = s_r;
    cmd.seg_n     = n_r;
    cmd.coord     = k_r;
    in_tready     = 1'b0;
    cfg_ready     = 1'b1;
    unique case (state_r)
      crct_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = crct_pkg::OP_CAPTURE;
        end
      end
      crct_pkg::ST_SEL_A: begin
        cmd.op     = crct_pkg::OP_SEL_A;
        cmd.hist_o = (seen_r == 2'd2) ? crct_pkg::HIST_AGE1 : crct_pkg::HIST_AGE2;
      end
      crct_pkg::ST_SEL_B: begin
        cmd.op     = crct_pkg::OP_SEL_B;
        cmd.hist_o = (seen_r == 2'd1) ? crct_pkg::HIST_AGE0 : crct_pkg::HIST_AGE1;
      end
      crct_pkg::ST_RAW1: cmd.op = crct_pkg::OP_RAW1;
      crct_pkg::ST_RAW2: cmd.op = crct_pkg::OP_RAW2;
      crct_pkg::ST_RAW3: cmd.op = crct_pkg::OP_RAW3;
      crct_pkg::ST_DIV:  cmd.op = crct_pkg::OP_DIV;
      crct_pkg::ST_MUL:  cmd.op = crct_pkg::OP_MUL;
      crct_pkg::ST_ACC:  cmd.op = crct_pkg::OP_ACC;
      crct_pkg::ST_LOAD: begin
        if (stat.out_free) begin
          cmd.op       = crct_pkg::OP_LOAD_CURVE;
          cmd.run_last = last_s_w && !phase_b_r && !do_b_r;
        end
      end
      crct_pkg::ST_PASS: begin
        if (stat.out_free) begin
          cmd.op        = crct_pkg::OP_LOAD_POINT;
          cmd.run_last  = 1'b1;
          cmd.curve_end = fin_r;
        end
      end
      crct_pkg::ST_FINAL: begin
        if (stat.out_free) begin
          cmd.op        = crct_pkg::OP_LOAD_POINT;
          cmd.run_last  = 1'b1;
          cmd.curve_end = 1'b1;
        end
      end
      crct_pkg::ST_DONE: cmd.op = crct_pkg::OP_PUSH;
      default: cmd.op = crct_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= crct_pkg::ST_IDLE;
      seg_r     <= crct_pkg::SEG_RESET;
      seen_r    <= 2'd0;
      n_r       <= '0;
      s_r       <= '0;
      cnt_r     <= '0;
      k_r       <= '0;
      fin_r     <= 1'b0;
      do_b_r    <= 1'b0;
      phase_b_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seen_r    <= seen_nxt;
      n_r       <= n_nxt;
      s_r       <= s_nxt;
      cnt_r     <= cnt_nxt;
      k_r       <= k_nxt;
      fin_r     <= fin_nxt;
      do_b_r    <= do_b_nxt;
      phase_b_r <= phase_b_nxt;
      if (cfg_valid) begin
        seg_r <= cfg_data;
      end
    end
  end

endmodule

// File: src/catmull_rom_curve_tessellator_core.sv
// For each curve point, states RAW1 to RAW3 form the basis terms, the weight
// dividers resolve one quotient bit per cycle, the weighting multipliers run per
// coordinate and the load passes the point on once the output register is free.
// Closing a curve also emits the final point, after an inner interval if one is
// emitted. A passed point is forwarded as it is; a point with no result is only
// stored in the history. Synchronous active-low reset: 20 segments, new curve.
`timescale 1ns / 1ps

module catmull_rom_curve_tessellator_core #(
  parameter int MAX_SEGMENTS = 31,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // point_x, point_y, point_z, zero pad
  input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                                     in_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // curve_x, curve_y, curve_z, zero pad
  output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                                     out_tlast,
  // curve_end
  output logic                                     out_tuser,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [crct_pkg::SEG_W-1:0]               cfg_data
);

  localparam int W = COORD_WIDTH;
  localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

  crct_pkg::dp_cmd_t  cmd;
  crct_pkg::dp_stat_t stat;

  logic signed [W-1:0] out_x, out_y, out_z;

  crct_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  crct_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_x      ($signed(in_tdata[W-1:0])),
    .in_y      ($signed(in_tdata[2*W-1:W])),
    .in_z      ($signed(in_tdata[3*W-1:2*W])),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_valid (out_tvalid),
    .out_last  (out_tlast),
    .out_end   (out_tuser),
    .out_ready (out_tready)
  );

  assign out_tdata = TDATA_W'({out_z, out_y, out_x});

endmodule
